>>> hw/rtl/tmq_pkg.sv
// Shared types and constants for the timed message queue.
`default_nettype none
package tmq_pkg;
    localparam int FIFO_DEPTH   = 16;
    localparam int TIMED_DEPTH  = 16;
    localparam int HANDLER_BITS = 8;
    localparam int FPTR_W = $clog2(FIFO_DEPTH);
    localparam int TPTR_W = $clog2(TIMED_DEPTH);
    localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int TCNT_W = $clog2(TIMED_DEPTH + 1);

    localparam logic [2:0] FUNC_ADD      = 3'd0;
    localparam logic [2:0] FUNC_POLL     = 3'd1;
    localparam logic [2:0] FUNC_DEL_H    = 3'd2;
    localparam logic [2:0] FUNC_DEL_HC   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;
    localparam logic [2:0] FUNC_NEXT     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_ms;
        logic        immediate;
        logic [31:0] due_time;
        logic [7:0]  handler_id;
        logic [15:0] msg_code;
    } req_t;

    typedef struct packed {
        logic        delivered;
        logic [7:0]  out_handler;
        logic [15:0] out_code;
        logic [31:0] out_due_time;
        logic        pending;
        logic [31:0] wake_time;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0]             due;
        logic [HANDLER_BITS-1:0] handler;
        logic [15:0]             code;
    } entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/timed_message_queue.sv
// Immediate add, clear, unused codes and next time with the FIFO occupied end after dispatch;
// a FIFO poll, a poll that is not yet due and a timed next time add one store read; a sorted
// insert, a timed poll and a delete walk the stores one entry per step.
// Throughput: one transaction at a time; s_tready is low while a transaction is worked and
// rises as the result is registered; the result waits in an output register.
// Reset: rst_n asynchronous active low clears counts, head pointer and handshakes.
`default_nettype none
module timed_message_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // func, now_ms, immediate, due_time, handler_id, msg_code, pad
    input  wire logic [95:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // delivered, out_handler, out_code, out_due_time, pending, wake_time, status, pad
    output logic [95:0]      m_tdata
);
    import tmq_pkg::*;

    logic   busy_reg;
    logic   oval_reg;
    rsp_t   out_reg;
    req_t   req;
    rsp_t   rsp;
    logic   done;
    logic   start;

    assign req.func       = s_tdata[2:0];
    assign req.now_ms     = s_tdata[34:3];
    assign req.immediate  = s_tdata[35];
    assign req.due_time   = s_tdata[67:36];
    assign req.handler_id = s_tdata[75:68];
    assign req.msg_code   = s_tdata[91:76];

    assign s_tready = !busy_reg;
    assign start = s_tvalid && s_tready;

    tmq_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .hold  (oval_reg && !m_tready),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            oval_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (done && !(oval_reg && !m_tready))
            begin
                busy_reg <= 1'b0;
            end
            if (done && !(oval_reg && !m_tready))
            begin
                oval_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && !(oval_reg && !m_tready))
        begin
            out_reg <= rsp;
        end
    end

    assign m_tvalid = oval_reg;
    assign m_tdata = {4'd0, out_reg.status, out_reg.wake_time, out_reg.pending,
                      out_reg.out_due_time, out_reg.out_code, out_reg.out_handler,
                      out_reg.delivered};
endmodule
`default_nettype wire

>>> hw/rtl/tmq_engine.sv
// Sequencer that walks both stores one entry per cycle.
`default_nettype none
module tmq_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic           hold,
    input  wire tmq_pkg::req_t  req,
    output logic                done,
    output tmq_pkg::rsp_t       rsp
);
    import tmq_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_FIND   = 4'd2;
    localparam logic [3:0] S_SHIFT  = 4'd3;
    localparam logic [3:0] S_PRD    = 4'd4;
    localparam logic [3:0] S_PSHIFT = 4'd5;
    localparam logic [3:0] S_FSWEEP = 4'd6;
    localparam logic [3:0] S_TSWEEP = 4'd7;
    localparam logic [3:0] S_HEAD   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_FRD    = 4'd10;

    logic [3:0] state_reg, state_next;
    req_t req_reg;
    rsp_t rsp_reg, rsp_next;

    entry_t fmem [FIFO_DEPTH];
    entry_t tmem [TIMED_DEPTH];

    logic [FPTR_W-1:0] fhead_reg, fhead_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [TCNT_W-1:0] tcnt_reg, tcnt_next;
    logic [TCNT_W-1:0] idx_reg, idx_next;
    logic [TCNT_W-1:0] wr_reg, wr_next;
    logic              hit_reg, hit_next;
    entry_t            rd_reg;

    logic              twe, fwe;
    logic [TPTR_W-1:0] twa, tra;
    logic [FPTR_W-1:0] fwa, fra;
    entry_t            twd, fwd;
    logic [HANDLER_BITS-1:0] hmask;
    logic              match;
    entry_t            new_e;

    assign hmask = req_reg.handler_id[HANDLER_BITS-1:0];
    assign new_e = '{due: req_reg.immediate ? 32'd0 : req_reg.due_time,
                     handler: hmask, code: req_reg.msg_code};
    assign match = (rd_reg.handler == hmask) &&
                   (req_reg.func != FUNC_DEL_HC || rd_reg.code == req_reg.msg_code);

    always_ff @(posedge clk)
    begin
        if (twe)
        begin
            tmem[twa] <= twd;
        end
        if (fwe)
        begin
            fmem[fwa] <= fwd;
        end
    end

    // the next state selects which store is read into rd_reg
    always_ff @(posedge clk)
    begin
        if (state_next == S_FSWEEP || state_next == S_FRD)
        begin
            rd_reg <= fmem[fra];
        end
        else
        begin
            rd_reg <= tmem[tra];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        fhead_next = fhead_reg;
        fcnt_next  = fcnt_reg;
        tcnt_next  = tcnt_reg;
        idx_next   = idx_reg;
        wr_next    = wr_reg;
        hit_next   = hit_reg;
        twe = 1'b0; twa = '0; twd = new_e;
        fwe = 1'b0; fwa = '0; fwd = rd_reg;
        tra = '0; fra = fhead_reg;
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISP;
                    rsp_next = '0;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (req_reg.func)
                    FUNC_ADD:
                    begin
                        if (req_reg.immediate)
                        begin
                            if (fcnt_reg == FCNT_W'(FIFO_DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                fwe = 1'b1;
                                fwa = FPTR_W'(fhead_reg + FPTR_W'(fcnt_reg));
                                fwd = new_e;
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                        end
                        else if (tcnt_reg == TCNT_W'(TIMED_DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            idx_next = '0;
                            tra = '0;
                            state_next = S_FIND;
                        end
                    end
                    FUNC_POLL:
                    begin
                        if (fcnt_reg != '0)
                        begin
                            fra = fhead_reg;
                            state_next = S_FRD;
                        end
                        else if (tcnt_reg != '0)
                        begin
                            tra = '0;
                            state_next = S_PRD;
                        end
                    end
                    FUNC_DEL_H, FUNC_DEL_HC:
                    begin
                        idx_next = '0;
                        wr_next = '0;
                        hit_next = 1'b0;
                        fra = fhead_reg;
                        state_next = (fcnt_reg != '0) ? S_FSWEEP : S_TSWEEP;
                    end
                    FUNC_CLEAR:
                    begin
                        fhead_next = '0;
                        fcnt_next = '0;
                        tcnt_next = '0;
                    end
                    FUNC_NEXT:
                    begin
                        if (fcnt_reg != '0)
                        begin
                            rsp_next.pending = 1'b1;
                            rsp_next.wake_time = req_reg.now_ms;
                        end
                        else if (tcnt_reg != '0)
                        begin
                            tra = '0;
                            state_next = S_HEAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FIND:
            begin
                // rd_reg holds entry idx_reg
                if (idx_reg < tcnt_reg && rd_reg.due < req_reg.due_time)
                begin
                    idx_next = idx_reg + 1'b1;
                    tra = TPTR_W'(idx_reg + 1'b1);
                end
                else
                begin
                    wr_next = tcnt_reg;
                    tra = TPTR_W'(tcnt_reg - 1'b1);
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // wr_reg is slot to fill; rd_reg holds slot wr_reg-1
                if (wr_reg == idx_reg)
                begin
                    twe = 1'b1;
                    twa = TPTR_W'(idx_reg);
                    twd = new_e;
                    tcnt_next = tcnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    twe = 1'b1;
                    twa = TPTR_W'(wr_reg);
                    twd = rd_reg;
                    wr_next = wr_reg - 1'b1;
                    tra = TPTR_W'(wr_reg - 2'd2);
                end
            end
            S_FRD:
            begin
                rsp_next.delivered = 1'b1;
                rsp_next.out_handler = 8'(rd_reg.handler);
                rsp_next.out_code = rd_reg.code;
                fhead_next = fhead_reg + 1'b1;
                fcnt_next = fcnt_reg - 1'b1;
                state_next = S_DONE;
            end
            S_PRD:
            begin
                if (rd_reg.due <= req_reg.now_ms)
                begin
                    rsp_next.delivered = 1'b1;
                    rsp_next.out_handler = 8'(rd_reg.handler);
                    rsp_next.out_code = rd_reg.code;
                    rsp_next.out_due_time = rd_reg.due;
                    idx_next = TCNT_W'(1);
                    tra = TPTR_W'(1);
                    state_next = S_PSHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PSHIFT:
            begin
                if (idx_reg >= tcnt_reg)
                begin
                    tcnt_next = tcnt_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    twe = 1'b1;
                    twa = TPTR_W'(idx_reg - 1'b1);
                    twd = rd_reg;
                    idx_next = idx_reg + 1'b1;
                    tra = TPTR_W'(idx_reg + 1'b1);
                end
            end
            S_FSWEEP:
            begin
                if (match)
                begin
                    hit_next = 1'b1;
                end
                else
                begin
                    fwe = 1'b1;
                    fwa = FPTR_W'(fhead_reg + FPTR_W'(wr_reg));
                    fwd = rd_reg;
                    wr_next = wr_reg + 1'b1;
                end
                if (TCNT_W'(idx_reg) + 1'b1 >= TCNT_W'(fcnt_reg))
                begin
                    fcnt_next = FCNT_W'(wr_next);
                    idx_next = '0;
                    wr_next = '0;
                    tra = '0;
                    state_next = S_TSWEEP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    fra = FPTR_W'(fhead_reg + FPTR_W'(idx_reg + 1'b1));
                end
            end
            S_TSWEEP:
            begin
                if (idx_reg >= tcnt_reg)
                begin
                    tcnt_next = wr_reg;
                    rsp_next.status = hit_reg ? ST_OK : ST_NOMATCH;
                    state_next = S_DONE;
                end
                else
                begin
                    if (match)
                    begin
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        twe = 1'b1;
                        twa = TPTR_W'(wr_reg);
                        twd = rd_reg;
                        wr_next = wr_reg + 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                    tra = TPTR_W'(idx_reg + 1'b1);
                end
            end
            S_HEAD:
            begin
                rsp_next.pending = 1'b1;
                rsp_next.wake_time = (req_reg.now_ms <= rd_reg.due) ? rd_reg.due
                                                                     : req_reg.now_ms;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // wait here while the output register is still occupied
                done = 1'b1;
                if (!hold)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fhead_reg <= '0;
            fcnt_reg  <= '0;
            tcnt_reg  <= '0;
            idx_reg   <= '0;
            wr_reg    <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fhead_reg <= fhead_next;
            fcnt_reg  <= fcnt_next;
            tcnt_reg  <= tcnt_next;
            idx_reg   <= idx_next;
            wr_reg    <= wr_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (start && state_reg == S_IDLE)
        begin
            req_reg <= req;
        end
    end

    assign rsp = rsp_reg;
endmodule
`default_nettype wire

>>> hw/rtl/tmq_checker.sv
// Port-level checker bound to the timed message queue.
`default_nettype none
module tmq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[91:90] != 2'd3)
        else $error("bad status");
    a_deliv: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[56:1] == 56'd0)
        else $error("delivery fields without delivery");
endmodule

bind timed_message_queue tmq_checker u_tmq_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

>>> test/timed_message_queue_chk.sv
// Checker for the timed message queue: predicts each response and compares it to the output.
module timed_message_queue_chk
    import tmq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    output int               errors,
    output int               outstanding,
    output int               checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] wake_time;
        logic        pending;
        logic [31:0] out_due_time;
        logic [15:0] out_code;
        logic [7:0]  out_handler;
        logic        delivered;
    } resp_t;

    entry_t      fifo_q [FIFO_DEPTH];
    int          fifo_rd;
    int          fifo_n;
    entry_t      sched_q [TIMED_DEPTH];
    int          sched_n;
    resp_t       expected_resp [$];

    function automatic bit hit(entry_t e, logic [7:0] h, logic [15:0] c, bit by_code);
        return e.handler == h && (!by_code || e.code == c);
    endfunction

    function automatic resp_t queue_apply(logic [95:0] d);
        logic [2:0]  fn;
        logic [31:0] now;
        logic        imm;
        logic [31:0] due;
        logic [7:0]  h;
        logic [15:0] c;
        resp_t       r;
        entry_t      e;
        entry_t      keep [FIFO_DEPTH];
        int          n;
        int          pos;
        bit          removed;
        fn  = d[2:0];
        now = d[34:3];
        imm = d[35];
        due = d[67:36];
        h   = d[75:68];
        c   = d[91:76];
        r   = '0;
        e.handler = h;
        e.code    = c;
        e.due     = imm ? 32'd0 : due;
        case (fn)
            FUNC_ADD:
                if (imm) begin
                    if (fifo_n >= FIFO_DEPTH) r.status = ST_FULL;
                    else begin
                        fifo_q[(fifo_rd + fifo_n) % FIFO_DEPTH] = e;
                        fifo_n++;
                    end
                end else begin
                    if (sched_n >= TIMED_DEPTH) r.status = ST_FULL;
                    else begin
                        pos = 0;
                        while (pos < sched_n && sched_q[pos].due < due) pos++;
                        for (int i = sched_n; i > pos; i--) sched_q[i] = sched_q[i-1];
                        sched_q[pos] = e;
                        sched_n++;
                    end
                end
            FUNC_POLL:
                if (fifo_n > 0) begin
                    e = fifo_q[fifo_rd];
                    fifo_rd = (fifo_rd + 1) % FIFO_DEPTH;
                    fifo_n--;
                    r.delivered = 1'b1;
                    r.out_handler = e.handler;
                    r.out_code = e.code;
                end else if (sched_n > 0 && sched_q[0].due <= now) begin
                    e = sched_q[0];
                    for (int i = 1; i < sched_n; i++) sched_q[i-1] = sched_q[i];
                    sched_n--;
                    r.delivered = 1'b1;
                    r.out_handler = e.handler;
                    r.out_code = e.code;
                    r.out_due_time = e.due;
                end
            FUNC_DEL_H, FUNC_DEL_HC: begin
                removed = 0;
                n = 0;
                for (int i = 0; i < fifo_n; i++) begin
                    e = fifo_q[(fifo_rd + i) % FIFO_DEPTH];
                    if (hit(e, h, c, fn == FUNC_DEL_HC)) removed = 1;
                    else keep[n++] = e;
                end
                for (int i = 0; i < n; i++) fifo_q[(fifo_rd + i) % FIFO_DEPTH] = keep[i];
                fifo_n = n;
                n = 0;
                for (int i = 0; i < sched_n; i++) begin
                    if (hit(sched_q[i], h, c, fn == FUNC_DEL_HC)) removed = 1;
                    else sched_q[n++] = sched_q[i];
                end
                sched_n = n;
                if (!removed) r.status = ST_NOMATCH;
            end
            FUNC_CLEAR: begin
                fifo_rd = 0;
                fifo_n  = 0;
                sched_n = 0;
            end
            FUNC_NEXT:
                if (fifo_n > 0) begin
                    r.pending = 1'b1;
                    r.wake_time = now;
                end else if (sched_n > 0) begin
                    r.pending = 1'b1;
                    r.wake_time = (now <= sched_q[0].due) ? sched_q[0].due : now;
                end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        resp_t got;
        resp_t want;
        if (!rst_n) begin
            fifo_rd = 0;
            fifo_n  = 0;
            sched_n = 0;
            errors  = 0;
            checked = 0;
            expected_resp.delete();
            outstanding = 0;
        end else begin
            if (s_tvalid && s_tready)
                expected_resp.insert(expected_resp.size(), queue_apply(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[91:0];
                checked++;
                if (expected_resp.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, got);
                    errors++;
                end else begin
                    want = expected_resp[0];
                    expected_resp.delete(0);
                    if (got !== want) begin
                        $display("%0t: mismatch expected dlv=%0d h=%h c=%h due=%h pend=%0d wake=%h st=%0d",
                                 $time, want.delivered, want.out_handler, want.out_code,
                                 want.out_due_time, want.pending, want.wake_time, want.status);
                        $display("%0t:          actual   dlv=%0d h=%h c=%h due=%h pend=%0d wake=%h st=%0d",
                                 $time, got.delivered, got.out_handler, got.out_code,
                                 got.out_due_time, got.pending, got.wake_time, got.status);
                        errors++;
                    end
                end
            end
            outstanding = expected_resp.size();
        end
    end
endmodule

>>> test/timed_message_queue_tb.sv
// Testbench top for the timed message queue: stimulus, flow control and verdict.
module timed_message_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tmq_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int IDLE_LIMIT   = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    int          errors;
    int          outstanding;
    int          checked;
    int          sent;
    int          idle_cycles;
    bit          hold_request;
    logic [31:0] clock_ms;

    timed_message_queue dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    timed_message_queue_chk chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .outstanding(outstanding), .checked(checked)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send(logic [2:0] fn, logic [31:0] now, logic imm, logic [31:0] due,
                        logic [7:0] h, logic [15:0] c);
        int g;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, c, h, due, imm, now, fn};
        forever
        begin
            @(negedge clk);
            if (s_tready) break;
            @(posedge clk);
        end
        @(posedge clk);
        sent++;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int p;
        logic [2:0]  fn;
        logic [31:0] now;
        logic [31:0] due;
        logic [7:0]  h;
        logic [15:0] c;
        clock_ms += $urandom_range(0, 20);
        now = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;
        p = $urandom_range(0, 9);
        if (p == 0) due = $urandom();
        else if (p == 1) due = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else due = clock_ms + $urandom_range(0, 150);
        h = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
        c = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
        p = $urandom_range(0, 99);
        if (p < 45) fn = FUNC_ADD;
        else if (p < 72) fn = FUNC_POLL;
        else if (p < 84) fn = FUNC_NEXT;
        else if (p < 90) fn = FUNC_DEL_H;
        else if (p < 96) fn = FUNC_DEL_HC;
        else if (p < 98) fn = FUNC_CLEAR;
        else fn = 3'($urandom_range(6, 7));
        send(fn, now, 1'($urandom_range(0, 1)), due, h, c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_request)
        begin
            m_tready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_request = 0;
        end
        else
            m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 7) == 0);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("timed_message_queue_tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        sent = 0;
        idle_cycles = 0;
        hold_request = 0;
        clock_ms = 100;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue behavior
        send(FUNC_POLL, 32'd0, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_NEXT, 32'hFFFF_FFFF, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_DEL_H, 32'd0, 1'b0, 32'd0, 8'hFF, 16'd0);
        // equal due times, extremes of fields
        send(FUNC_ADD, 32'd0, 1'b0, 32'd50, 8'h01, 16'h0001);
        send(FUNC_ADD, 32'd0, 1'b0, 32'd50, 8'h02, 16'h0002);
        send(FUNC_ADD, 32'd0, 1'b0, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(FUNC_ADD, 32'd0, 1'b0, 32'd0, 8'h00, 16'h0000);
        send(FUNC_NEXT, 32'd10, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_POLL, 32'd49, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_POLL, 32'd49, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_NEXT, 32'd60, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hAA, 16'h5555);
        send(FUNC_NEXT, 32'hFFFF_FFFF, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_POLL, 32'd0, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_DEL_HC, 32'd0, 1'b0, 32'd0, 8'h02, 16'h0003);
        send(FUNC_DEL_HC, 32'd0, 1'b0, 32'd0, 8'h02, 16'h0002);
        send(3'd6, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
        send(3'd7, 32'd0, 1'b0, 32'd0, 8'd0, 16'd0);
        for (int i = 0; i < 17; i++)
            send(FUNC_ADD, 32'd0, 1'b1, 32'd0, i[7:0], i[15:0]);
        for (int i = 0; i < 17; i++)
            send(FUNC_ADD, 32'd0, 1'b0, 32'd17 - i[31:0], 8'h01, i[15:0]);
        send(FUNC_DEL_H, 32'd0, 1'b0, 32'd0, 8'h01, 16'd0);
        send(FUNC_POLL, 32'hFFFF_FFFF, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_CLEAR, 32'd0, 1'b0, 32'd0, 8'd0, 16'd0);
        send(FUNC_POLL, 32'hFFFF_FFFF, 1'b0, 32'd0, 8'd0, 16'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300) hold_request = 1;
            send_random();
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d transactions (adds, polls, deletes, clears, wake queries, unused codes)",
                 sent);
        $display("checked %0d responses, including full stores and a long output stall", checked);
        if (errors == 0 && outstanding == 0)
            $display("timed_message_queue_tb passed");
        else
            $display("timed_message_queue_tb failed");
        $finish;
    end
endmodule

>>> timed_message_queue.f
hw/rtl/tmq_pkg.sv
hw/rtl/tmq_engine.sv
hw/rtl/timed_message_queue.sv
hw/rtl/tmq_checker.sv
test/timed_message_queue_chk.sv
test/timed_message_queue_tb.sv
